// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/llae_pkg.sv -----
// ----------------------------------------------------------------------------
// llae_pkg
// Shared types, codes and reset values of the life-like automaton engine.
// ----------------------------------------------------------------------------
`default_nettype none

package llae_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  typedef logic [1:0]  mode_t;
  typedef logic [5:0]  coord_t;
  typedef logic [7:0]  cell_t;
  typedef logic [31:0] count_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [8:0]  cfg_data_t;

  localparam mode_t MODE_WRITE = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_STEP  = 2'd2;
  localparam mode_t MODE_CLEAR = 2'd3;

  localparam cfg_index_t CFG_WIDTH   = 2'd0;
  localparam cfg_index_t CFG_HEIGHT  = 2'd1;
  localparam cfg_index_t CFG_BIRTH   = 2'd2;
  localparam cfg_index_t CFG_SURVIVE = 2'd3;

  // B3/S23
  localparam logic [6:0] RST_WIDTH   = 7'd64;
  localparam logic [6:0] RST_HEIGHT  = 7'd64;
  localparam logic [8:0] RST_BIRTH   = 9'd8;
  localparam logic [8:0] RST_SURVIVE = 9'd12;

  // Neighborhood read steps: center first, then eight neighbors.
  localparam logic [3:0] STEP_CENTER = 4'd0;
  localparam logic [3:0] STEP_LAST   = 4'd8;

endpackage

`default_nettype wire

// ----- design/llae_if.sv -----
// ----------------------------------------------------------------------------
// llae_req_if / llae_rsp_if
// Valid/ready channels for requests and responses of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface llae_req_if import llae_pkg::*; ();
  logic   valid;
  logic   ready;
  mode_t  mode;
  coord_t col;
  coord_t row;
  cell_t  cell_value;

  modport source (output valid, mode, col, row, cell_value, input ready);
  modport sink   (input valid, mode, col, row, cell_value, output ready);
endinterface

interface llae_rsp_if import llae_pkg::*; ();
  logic   valid;
  logic   ready;
  cell_t  read_value;
  count_t generation_count;

  modport source (output valid, read_value, generation_count, input ready);
  modport sink   (input valid, read_value, generation_count, output ready);
endinterface

`default_nettype wire

// ----- design/life_like_automaton_engine.sv -----
// ----------------------------------------------------------------------------
// life_like_automaton_engine
// Toroidal life-like cellular automaton over a grid of byte cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: write a cell, read a cell, run
//   one generation, or clear the generation counter. rsp returns exactly one
//   transaction per command: the cell byte (reads only, else zero) and the
//   generation count after the command. Configuration (size, birth and
//   survive masks) is written through cfg_we/cfg_index/cfg_data; the user
//   must do so only while the engine is idle; the engine does not enforce it.
// Flow: a write or clear passes through EXEC and FIN after acceptance, a read
//   through EXEC, RDW and FIN. A generation walks all MAX_COLS*MAX_ROWS stored
//   cells, reading the center and eight neighbors of each through the single
//   read port of the cell store, then passes through DRAIN and FIN.
//   One command is worked at a time; the next is taken once the result is in
//   the output register, even if that result is not yet taken.
// Reset: the store's live bank is swept to zero, one cell per cycle, over all
//   MAX_COLS*MAX_ROWS cells; req stays not ready during the sweep.
// Stall: a result held in the output register keeps its value until taken;
//   a finished command waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_engine import llae_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire cfg_index_t cfg_index,
  input  wire cfg_data_t  cfg_data,
  llae_req_if.sink        req,
  llae_rsp_if.source      rsp
);

  localparam int NCELL = MAX_COLS * MAX_ROWS;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = $clog2(NCELL);
  localparam int MAW   = AW + 1;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_GEN   = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  // Cell index of a (column, row) pair in one bank.
  function automatic logic [AW-1:0] cell_idx(input logic [CW-1:0] c,
                                             input logic [RW-1:0] r);
    cell_idx = AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  // Store address of a cell in a bank.
  function automatic logic [MAW-1:0] bank_addr(input logic b, input logic [AW-1:0] i);
    bank_addr = b ? MAW'(i) + MAW'(NCELL) : MAW'(i);
  endfunction

  logic [2:0]    state;
  logic [6:0]    grid_width;
  logic [6:0]    grid_height;
  logic [8:0]    birth_mask;
  logic [8:0]    survive_mask;
  logic          bank;
  logic [AW-1:0] clr_idx;
  count_t        gen_cnt;
  logic          out_valid;
  cell_t         out_read;
  count_t        out_count;

  // Request latched at acceptance.
  mode_t         cur_mode;
  logic [AW-1:0] cur_idx;
  cell_t         cur_value;
  cell_t         rd_val;

  // Generation scan.
  logic [3:0]    k;
  logic [CW-1:0] sc;
  logic [RW-1:0] sr;
  logic          rv;
  logic [3:0]    k_d;
  logic [AW-1:0] widx_d;
  logic          act_d;
  cell_t         center;
  logic [3:0]    nbr;

  logic [CW:0]    w_eff;
  logic [RW:0]    h_eff;
  logic [CW-1:0]  lf, rt, req_col;
  logic [RW-1:0]  up, dn, req_row;
  logic           scan_act;
  logic [AW-1:0]  gen_idx;
  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  cell_t          mem_wdata;
  logic [MAW-1:0] mem_raddr;
  cell_t          mem_rdata;
  logic           rd_alive;
  logic [3:0]     n_total;
  cell_t          new_cell;
  logic           last_cell;
  logic           out_free;

  // Size clamped into 1..MAX.
  always_comb begin
    if (grid_width == 7'd0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(grid_width) > 32'(MAX_COLS)) begin
      w_eff = (CW+1)'(MAX_COLS);
    end else begin
      w_eff = (CW+1)'(grid_width);
    end
    if (grid_height == 7'd0) begin
      h_eff = (RW+1)'(1);
    end else if (32'(grid_height) > 32'(MAX_ROWS)) begin
      h_eff = (RW+1)'(MAX_ROWS);
    end else begin
      h_eff = (RW+1)'(grid_height);
    end
  end

  // Wrap request coordinates past the active edge to zero.
  assign req_col = (32'(req.col) >= 32'(w_eff)) ? '0 : CW'(req.col);
  assign req_row = (32'(req.row) >= 32'(h_eff)) ? '0 : RW'(req.row);

  // Toroidal neighbors of the scan position within the active area.
  assign lf = (sc == '0) ? CW'(w_eff - (CW+1)'(1)) : sc - CW'(1);
  assign rt = (({1'b0, sc} + (CW+1)'(1)) >= w_eff) ? '0 : sc + CW'(1);
  assign up = (sr == '0) ? RW'(h_eff - (RW+1)'(1)) : sr - RW'(1);
  assign dn = (({1'b0, sr} + (RW+1)'(1)) >= h_eff) ? '0 : sr + RW'(1);
  assign scan_act = ({1'b0, sc} < w_eff) && ({1'b0, sr} < h_eff);

  always_comb begin
    case (k)
      4'd1:    gen_idx = cell_idx(lf, up);
      4'd2:    gen_idx = cell_idx(sc, up);
      4'd3:    gen_idx = cell_idx(rt, up);
      4'd4:    gen_idx = cell_idx(lf, sr);
      4'd5:    gen_idx = cell_idx(rt, sr);
      4'd6:    gen_idx = cell_idx(lf, dn);
      4'd7:    gen_idx = cell_idx(sc, dn);
      4'd8:    gen_idx = cell_idx(rt, dn);
      default: gen_idx = cell_idx(sc, sr);
    endcase
  end

  assign last_cell = (k == STEP_LAST) && (32'(sc) == MAX_COLS - 1) &&
                     (32'(sr) == MAX_ROWS - 1);

  // Rule applied when the last neighbor byte returns.
  assign rd_alive = (mem_rdata != '0);
  assign n_total  = nbr + 4'(rd_alive);
  always_comb begin
    new_cell = center;
    if (act_d) begin
      if (center != '0) begin
        if (!survive_mask[n_total]) begin
          new_cell = '0;
        end
      end else if (birth_mask[n_total]) begin
        new_cell = 8'd1;
      end
    end
  end

  // Store port control: sweep, cell write, or generation write-back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bank_addr(~bank, widx_d);
    mem_wdata = new_cell;
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = bank_addr(1'b0, clr_idx);
      mem_wdata = '0;
    end else if (state == S_EXEC && cur_mode == MODE_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = bank_addr(bank, cur_idx);
      mem_wdata = cur_value;
    end else if (rv && k_d == STEP_LAST) begin
      mem_we    = 1'b1;
    end
    mem_raddr = (state == S_EXEC) ? bank_addr(bank, cur_idx) : bank_addr(bank, gen_idx);
  end

  llae_grid_mem #(
    .DEPTH (2 * NCELL),
    .AW    (MAW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      bank         <= 1'b0;
      gen_cnt      <= '0;
      out_valid    <= 1'b0;
      rv           <= 1'b0;
      k            <= '0;
      sc           <= '0;
      sr           <= '0;
      grid_width   <= RST_WIDTH;
      grid_height  <= RST_HEIGHT;
      birth_mask   <= RST_BIRTH;
      survive_mask <= RST_SURVIVE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:   grid_width   <= cfg_data[6:0];
          CFG_HEIGHT:  grid_height  <= cfg_data[6:0];
          CFG_BIRTH:   birth_mask   <= cfg_data;
          CFG_SURVIVE: survive_mask <= cfg_data;
          default: ;
        endcase
      end

      rv <= (state == S_GEN);

      // Load the output register, or drop it once the result is taken.
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + AW'(1);
          if (32'(clr_idx) == NCELL - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cur_mode)
            MODE_WRITE: state <= S_FIN;
            MODE_READ:  state <= S_RDW;
            MODE_STEP: begin
              k     <= STEP_CENTER;
              sc    <= '0;
              sr    <= '0;
              state <= S_GEN;
            end
            MODE_CLEAR: begin
              gen_cnt <= '0;
              state   <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_RDW: state <= S_FIN;
        S_GEN: begin
          // Advance the read step, then the cell position.
          if (k == STEP_LAST) begin
            k <= STEP_CENTER;
            if (32'(sc) == MAX_COLS - 1) begin
              sc <= '0;
              sr <= sr + RW'(1);
            end else begin
              sc <= sc + CW'(1);
            end
          end else begin
            k <= k + 4'd1;
          end
          if (last_cell) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Last write-back lands this cycle; swap banks.
          bank    <= ~bank;
          gen_cnt <= gen_cnt + 32'd1;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cur_mode  <= req.mode;
      cur_idx   <= cell_idx(req_col, req_row);
      cur_value <= req.cell_value;
      rd_val    <= '0;
    end
    if (state == S_RDW) begin
      rd_val <= mem_rdata;
    end
    k_d    <= k;
    widx_d <= cell_idx(sc, sr);
    act_d  <= scan_act;
    if (rv) begin
      if (k_d == STEP_CENTER) begin
        center <= mem_rdata;
        nbr    <= '0;
      end else begin
        nbr <= nbr + 4'(rd_alive);
      end
    end
    if (state == S_FIN && out_free) begin
      out_read  <= rd_val;
      out_count <= gen_cnt;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.read_value       = out_read;
  assign rsp.generation_count = out_count;

endmodule

`default_nettype wire

// ----- design/llae_grid_mem.sv -----
// ----------------------------------------------------------------------------
// llae_grid_mem
// Two-bank cell store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module llae_grid_mem import llae_pkg::*; #(
  parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS * 2,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire cell_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output cell_t              rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/llae_checker.sv -----
// ----------------------------------------------------------------------------
// llae_checker
// Port-level checks of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module llae_checker import llae_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   req_valid,
  input wire logic   req_ready,
  input wire logic   rsp_valid,
  input wire logic   rsp_ready,
  input wire cell_t  rsp_read_value,
  input wire count_t rsp_generation_count
);

  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_generation_count), "response changed while stalled")
  `ASSERT_CLK(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "second transaction taken while busy")
  `ASSERT_ALWAYS(a_rst_rsp, clk, rst |=> !rsp_valid, "response valid right after reset")
  `ASSERT_ALWAYS(a_rst_sweep, clk, rst |=> !req_ready, "request taken during clearing sweep")

endmodule

bind life_like_automaton_engine llae_checker u_llae_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_read_value       (rsp.read_value),
  .rsp_generation_count (rsp.generation_count)
);

`default_nettype wire

// ----- tb/tb_life_like_automaton_engine.sv -----
// ----------------------------------------------------------------------------
// tb_life_like_automaton_engine
// Self-checking bench for the toroidal life-like automaton engine.
// ----------------------------------------------------------------------------
// Drives cell writes, reads, generations and counter clears through the
// request channel. A behavioral copy of the grid predicts each response, and
// responses are checked in order, field by field. The size and rule registers
// are changed between test phases, only while the engine is idle. Both
// channel sides back off at random in two idle mixes; a third has none.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_life_like_automaton_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import llae_pkg::*;

  localparam int COLS = DEF_MAX_COLS;
  localparam int ROWS = DEF_MAX_ROWS;

  typedef struct packed {
    cell_t  read_value;
    count_t generation_count;
  } cell_rsp_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  llae_req_if req_ch ();
  llae_rsp_if rsp_ch ();

  life_like_automaton_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch.sink),
    .rsp      (rsp_ch.source)
  );

  // Shadow of the engine state: grid bytes, counter, registers.
  cell_t      shadow_grid [COLS*ROWS];
  count_t     shadow_gens;
  logic [6:0] shadow_width;
  logic [6:0] shadow_height;
  logic [8:0] shadow_birth;
  logic [8:0] shadow_survive;

  cell_rsp_t pending_rsp_q[$];
  int        mismatches;
  int        checked_rsps;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        generations_run;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; the slowest legal run stays well under this.
  initial begin
    #60_000_000;
    $display("tb_life_like_automaton_engine NOT OK");
    $finish;
  end

  function automatic int active_cols();
    if (shadow_width == 0) return 1;
    if (shadow_width > COLS) return COLS;
    return int'(shadow_width);
  endfunction

  function automatic int active_rows();
    if (shadow_height == 0) return 1;
    if (shadow_height > ROWS) return ROWS;
    return int'(shadow_height);
  endfunction

  // Advance the shadow grid by one generation; every new cell comes from the
  // old grid, and cells outside the active area are left alone.
  function automatic void evolve_grid();
    cell_t old_grid [COLS*ROWS];
    int    w;
    int    h;
    int    up;
    int    dn;
    int    lf;
    int    rt;
    int    n;
    logic  alive;
    w = active_cols();
    h = active_rows();
    old_grid = shadow_grid;
    for (int r = 0; r < h; r++) begin
      up = (r == 0) ? h - 1 : r - 1;
      dn = (r + 1 >= h) ? 0 : r + 1;
      for (int c = 0; c < w; c++) begin
        lf = (c == 0) ? w - 1 : c - 1;
        rt = (c + 1 >= w) ? 0 : c + 1;
        alive = old_grid[r*COLS + c] != 0;
        n = (old_grid[up*COLS + lf] != 0) + (old_grid[up*COLS + c] != 0)
          + (old_grid[up*COLS + rt] != 0) + (old_grid[r*COLS + lf] != 0)
          + (old_grid[r*COLS + rt] != 0) + (old_grid[dn*COLS + lf] != 0)
          + (old_grid[dn*COLS + c] != 0) + (old_grid[dn*COLS + rt] != 0);
        if (alive && !shadow_survive[n]) shadow_grid[r*COLS + c] = 8'd0;
        if (!alive && shadow_birth[n])   shadow_grid[r*COLS + c] = 8'd1;
      end
    end
    shadow_gens += 1;
  endfunction

  // Apply one command to the shadow and return the response it must cause.
  function automatic cell_rsp_t apply_command(mode_t mode, coord_t col, coord_t row,
                                              cell_t value);
    cell_rsp_t rsp;
    int        c;
    int        r;
    c = int'(col);
    r = int'(row);
    if (c > active_cols() - 1) c = 0;
    if (r > active_rows() - 1) r = 0;
    rsp.read_value = 8'd0;
    case (mode)
      MODE_WRITE: shadow_grid[r*COLS + c] = value;
      MODE_READ:  rsp.read_value = shadow_grid[r*COLS + c];
      MODE_STEP:  evolve_grid();
      default:    shadow_gens = '0;
    endcase
    rsp.generation_count = shadow_gens;
    return rsp;
  endfunction

  // Send one command; hold valid across back-to-back commands and drop it
  // only when an idle gap is taken or the bench drains.
  task automatic send_command(mode_t mode, coord_t col, coord_t row, cell_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.mode       = mode;
    req_ch.col        = col;
    req_ch.row        = row;
    req_ch.cell_value = value;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    pending_rsp_q.push_back(apply_command(mode, col, row, value));
    if (mode == MODE_STEP) generations_run++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every response is back, plus a short margin.
  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write a register while idle and mirror it in the shadow.
  task automatic write_reg(cfg_index_t idx, cfg_data_t data);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WIDTH:  shadow_width   = data[6:0];
      CFG_HEIGHT: shadow_height  = data[6:0];
      CFG_BIRTH:  shadow_birth   = data;
      default:    shadow_survive = data;
    endcase
  endtask

  task automatic set_rule(int w, int h, cfg_data_t birth, cfg_data_t survive);
    write_reg(CFG_WIDTH, cfg_data_t'(w));
    write_reg(CFG_HEIGHT, cfg_data_t'(h));
    write_reg(CFG_BIRTH, birth);
    write_reg(CFG_SURVIVE, survive);
  endtask

  // Receiver: stall at the configured rate, updated at the falling edge.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Response checker: compare each transaction with the oldest prediction.
  always @(posedge clk) begin
    cell_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected response read=%0d gens=%0d",
                   rsp_ch.read_value, rsp_ch.generation_count);
      end else begin
        want = pending_rsp_q.pop_front();
        checked_rsps++;
        if (rsp_ch.read_value !== want.read_value ||
            rsp_ch.generation_count !== want.generation_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: response %0d read exp=%0d got=%0d, gens exp=%0d got=%0d",
                     checked_rsps, want.read_value, rsp_ch.read_value,
                     want.generation_count, rsp_ch.generation_count);
        end
      end
    end
  end

  // Extremes of every field, all four commands, and a blinker under B3/S23.
  task automatic test_directed();
    send_command(MODE_WRITE, 6'd0, 6'd0, 8'hFF);
    send_command(MODE_WRITE, 6'd63, 6'd63, 8'h01);
    send_command(MODE_WRITE, 6'd21, 6'd42, 8'hAA);
    send_command(MODE_WRITE, 6'd42, 6'd21, 8'h55);
    send_command(MODE_READ, 6'd0, 6'd0, 8'h00);
    send_command(MODE_READ, 6'd63, 6'd63, 8'hFF);
    send_command(MODE_READ, 6'd21, 6'd42, 8'h00);
    send_command(MODE_READ, 6'd42, 6'd21, 8'h00);
    send_command(MODE_WRITE, 6'd0, 6'd0, 8'h00);
    send_command(MODE_WRITE, 6'd63, 6'd63, 8'h00);
    // Horizontal blinker across the wrap edge.
    send_command(MODE_WRITE, 6'd63, 6'd10, 8'h07);
    send_command(MODE_WRITE, 6'd0, 6'd10, 8'h80);
    send_command(MODE_WRITE, 6'd1, 6'd10, 8'h02);
    send_command(MODE_STEP, 6'd0, 6'd0, 8'h00);
    send_command(MODE_READ, 6'd0, 6'd9, 8'h00);
    send_command(MODE_READ, 6'd0, 6'd10, 8'h00);
    send_command(MODE_READ, 6'd63, 6'd10, 8'h00);
    send_command(MODE_STEP, 6'd0, 6'd0, 8'h00);
    send_command(MODE_READ, 6'd1, 6'd10, 8'h00);
    send_command(MODE_CLEAR, 6'd5, 6'd5, 8'h5A);
    send_command(MODE_READ, 6'd0, 6'd10, 8'h00);
  endtask

  // Small and out-of-range sizes: coordinates past the edge fold to zero,
  // neighbors wrap onto themselves, cells outside the area stay put.
  task automatic test_tiny_grid();
    set_rule(1, 1, 9'h1FF, 9'h000);
    send_command(MODE_WRITE, 6'd9, 6'd9, 8'h33);
    send_command(MODE_READ, 6'd0, 6'd0, 8'h00);
    send_command(MODE_STEP, 6'd0, 6'd0, 8'h00);
    send_command(MODE_READ, 6'd3, 6'd0, 8'h00);
    set_rule(2, 2, 9'h100, 9'h100);
    send_command(MODE_WRITE, 6'd1, 6'd1, 8'hC3);
    send_command(MODE_WRITE, 6'd1, 6'd0, 8'h00);
    send_command(MODE_STEP, 6'd0, 6'd0, 8'h00);
    for (int i = 0; i < 4; i++)
      send_command(MODE_READ, coord_t'(i % 2), coord_t'(i / 2), 8'h00);
    // Width and height of zero and above the store size.
    set_rule(0, 127, 9'h008, 9'h00C);
    send_command(MODE_WRITE, 6'd5, 6'd62, 8'h11);
    send_command(MODE_READ, 6'd0, 6'd62, 8'h00);
    set_rule(100, 0, 9'h008, 9'h00C);
    send_command(MODE_READ, 6'd63, 6'd40, 8'h00);
    send_command(MODE_READ, 6'd10, 6'd10, 8'h00);
  endtask

  // Mask extremes: no birth and no survival, then birth and survival on every count.
  task automatic test_rule_extremes();
    set_rule(8, 5, 9'h000, 9'h000);
    send_command(MODE_WRITE, 6'd3, 6'd2, 8'h44);
    send_command(MODE_STEP, 6'd0, 6'd0, 8'h00);
    send_command(MODE_READ, 6'd3, 6'd2, 8'h00);
    set_rule(3, 64, 9'h1FF, 9'h1FF);
    send_command(MODE_STEP, 6'd0, 6'd0, 8'h00);
    send_command(MODE_READ, 6'd2, 6'd63, 8'h00);
    send_command(MODE_READ, 6'd3, 6'd7, 8'h00);
  endtask

  // Map loads with random content on random grid sizes and rules; at most
  // max_gens generations per phase, the rest cell traffic and noise.
  task automatic test_random_maps(int n_items, int max_gens);
    int     w;
    int     h;
    int     pick;
    int     gens_here;
    coord_t c;
    coord_t r;
    gens_here = 0;
    w = $urandom_range(64, 1);
    h = $urandom_range(64, 1);
    if ($urandom_range(3) == 0) begin
      w = $urandom_range(8, 3);
      h = $urandom_range(8, 3);
    end
    set_rule(w, h, cfg_data_t'($urandom_range(511)), cfg_data_t'($urandom_range(511)));
    send_command(MODE_CLEAR, coord_t'($urandom), coord_t'($urandom), cell_t'($urandom));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      // Mostly inside the area, sometimes anywhere to hit the fold.
      c = ($urandom_range(4) == 0) ? coord_t'($urandom) : coord_t'($urandom_range(w - 1));
      r = ($urandom_range(4) == 0) ? coord_t'($urandom) : coord_t'($urandom_range(h - 1));
      if (pick < 45)
        send_command(MODE_WRITE, c, r, cell_t'($urandom));
      else if (pick < 85)
        send_command(MODE_READ, c, r, cell_t'($urandom));
      else if (pick < 92 && gens_here < max_gens) begin
        send_command(MODE_STEP, c, r, cell_t'($urandom));
        gens_here++;
      end else
        send_command(MODE_CLEAR, c, r, cell_t'($urandom));
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_WIDTH;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.mode    = MODE_WRITE;
    req_ch.col     = '0;
    req_ch.row     = '0;
    req_ch.cell_value = '0;
    mismatches     = 0;
    checked_rsps   = 0;
    generations_run = 0;
    send_idle_pct  = 28;
    recv_idle_pct  = 74;
    foreach (shadow_grid[i]) shadow_grid[i] = '0;
    shadow_gens    = '0;
    shadow_width   = RST_WIDTH;
    shadow_height  = RST_HEIGHT;
    shadow_birth   = RST_BIRTH;
    shadow_survive = RST_SURVIVE;

    // Hold reset, then release it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_tiny_grid();
    test_rule_extremes();

    // Idle mixes: receiver-heavy, sender-heavy, then none.
    test_random_maps(24, 2);
    test_random_maps(24, 2);
    send_idle_pct = 74;
    recv_idle_pct = 28;
    test_random_maps(24, 2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_maps(24, 2);

    drain();
    repeat (50) @(negedge clk);

    $display("Covered %0d checked responses, %0d generations, sizes 1x1 to 64x64.",
             checked_rsps, generations_run);
    $display("Mismatching responses: %0d", mismatches + pending_rsp_q.size());
    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("tb_life_like_automaton_engine OK");
    end else begin
      $display("tb_life_like_automaton_engine NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/llae_pkg.sv
design/llae_if.sv
design/llae_grid_mem.sv
design/life_like_automaton_engine.sv
design/llae_checker.sv
tb/tb_life_like_automaton_engine.sv
